>>> sv/toeq_pkg.sv
package toeq_pkg;

  // Field widths fixed by the item formats
  localparam int unsigned TimeW   = 32;
  localparam int unsigned KindW   = 16;
  localparam int unsigned DataW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW    = 5;
  localparam int unsigned InDataW  = 112;
  localparam int unsigned OutDataW = 120;

  // Commands carried in the input tuser
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_POP    = 1'b1
  } cmd_t;

  // Result codes carried in the output tuser
  typedef enum logic [StatusW-1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // One stored event
  typedef struct packed {
    logic [DataW-1:0]        b;
    logic [DataW-1:0]        a;
    logic [KindW-1:0]        kind;
    logic signed [TimeW-1:0] time_key;
  } entry_t;

  // Per-cycle control broadcast to every cell
  typedef struct packed {
    logic ins;  // accepted insert into a queue that is not full
    logic pop;  // accepted pop from a queue that is not empty
  } ctrl_t;

endpackage

>>> sv/time_ordered_event_queue_unit.sv
// Sorted event queue of CAPACITY slots built as a row of cells, earliest
// event in cell 0. in_tuser selects insert or pop. An insert lands behind
// every stored event with an equal or smaller signed time, so equal times
// leave in arrival order; a pop returns the head and the rest move up one
// cell. Every item gives exactly one result: inserted, removed, empty (pop
// on an empty queue) or full (insert refused, queue unchanged). One item is
// taken per clock: all cells compare against the incoming time in the same
// cycle and the result lands in a single output register, so the rate is
// one item per cycle while out_tready is high, and in_tready drops only
// while a result waits unclaimed. No clearing pass is needed after reset.
module time_ordered_event_queue_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] event_time, [47:32] event_kind, [79:48] payload_a, [111:80] payload_b
  input  logic [111:0] in_tdata,
  // [0] cmd
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] out_time, [47:32] out_kind, [79:48] out_a, [111:80] out_b,
  // [112] is_empty, [117:113] occupancy, [119:118] zero
  output logic [119:0] out_tdata,
  // [1:0] status
  output logic [1:0]   out_tuser
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic                              in_acc;
  logic [CntW-1:0]                   count_r;
  logic [CntW-1:0]                   count_nxt;
  logic                              full;
  logic                              empty;
  toeq_pkg::ctrl_t                   ctrl;
  toeq_pkg::entry_t                  new_entry;
  toeq_pkg::entry_t                  cell_entry [CAPACITY];
  logic [CAPACITY-1:0]               cell_le;
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic [toeq_pkg::OutDataW-1:0]     out_data_r;
  logic [toeq_pkg::OutDataW-1:0]     out_data_nxt;
  toeq_pkg::status_t                 out_status_r;
  toeq_pkg::status_t                 out_status_nxt;
  toeq_pkg::entry_t                  res_entry;
  logic [toeq_pkg::OccW-1:0]         occ_out;

  // Output register frees the input side whenever it is empty or drained
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign new_entry.time_key = in_tdata[31:0];
  assign new_entry.kind     = in_tdata[47:32];
  assign new_entry.a        = in_tdata[79:48];
  assign new_entry.b        = in_tdata[111:80];

  assign full  = (count_r == CntW'(CAPACITY));
  assign empty = (count_r == '0);

  assign ctrl.ins = in_acc && (in_tuser[0] == toeq_pkg::CMD_INSERT) && !full;
  assign ctrl.pop = in_acc && (in_tuser[0] == toeq_pkg::CMD_POP) && !empty;

  // Row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             occ_i;
    logic             le_left_i;
    toeq_pkg::entry_t left_i;
    toeq_pkg::entry_t right_i;

    assign occ_i = (CntW'(i) < count_r);

    if (i == 0) begin : g_head
      assign le_left_i = 1'b1;
      assign left_i    = new_entry;
    end else begin : g_body
      assign le_left_i = cell_le[i-1];
      assign left_i    = cell_entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_i = cell_entry[i];
    end else begin : g_mid
      assign right_i = cell_entry[i+1];
    end

    toeq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occ        (occ_i),
      .new_entry  (new_entry),
      .le_left    (le_left_i),
      .left_entry (left_i),
      .right_entry(right_i),
      .le         (cell_le[i]),
      .entry      (cell_entry[i])
    );
  end

  // Occupancy update
  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + CntW'(1);
    end else if (ctrl.pop) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  // Result formation
  always_comb begin
    res_entry      = '0;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;
    occ_out        = toeq_pkg::OccW'(count_nxt);
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      out_valid_nxt = 1'b1;
      if (in_tuser[0] == toeq_pkg::CMD_INSERT) begin
        out_status_nxt = full ? toeq_pkg::ST_FULL : toeq_pkg::ST_INSERTED;
      end else if (empty) begin
        out_status_nxt = toeq_pkg::ST_EMPTY;
      end else begin
        out_status_nxt = toeq_pkg::ST_REMOVED;
        res_entry      = cell_entry[0];
      end
      out_data_nxt = {2'b00, occ_out, (count_nxt == '0),
                      res_entry.b, res_entry.a, res_entry.kind, res_entry.time_key};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(CAPACITY))
    else $error("occupancy above capacity");

  a_full_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser[0] == toeq_pkg::CMD_INSERT) && full |=>
      (count_r == CntW'(CAPACITY)) && (out_status_r == toeq_pkg::ST_FULL))
    else $error("insert into full queue changed occupancy");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.pop |=> (count_r == $past(count_r) - CntW'(1)))
    else $error("pop did not remove one event");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[112] == (out_data_r[117:113] == '0)))
    else $error("empty flag disagrees with occupancy");

endmodule

>>> sv/toeq_cell.sv
module toeq_cell (
  input  logic             clk,
  input  toeq_pkg::ctrl_t  ctrl,
  input  logic             occ,       // this slot holds a live event
  input  toeq_pkg::entry_t new_entry, // event being inserted
  input  logic             le_left,   // left neighbor keeps its event
  input  toeq_pkg::entry_t left_entry,
  input  toeq_pkg::entry_t right_entry,
  output logic             le,        // this cell keeps its event on insert
  output toeq_pkg::entry_t entry
);

  toeq_pkg::entry_t entry_r;
  toeq_pkg::entry_t entry_nxt;

  // Stored time not later than the new one: event stays ahead of it
  assign le = occ && ($signed(entry_r.time_key) <= $signed(new_entry.time_key));

  // Keep, take the new event, take the left neighbor, or take the right one
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins) begin
      if (!le) begin
        entry_nxt = le_left ? new_entry : left_entry;
      end
    end else if (ctrl.pop) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule
